// File: hdl/dqs_pkg.sv
// Package for the deque with linear search: capacity, widths, command and
// status codes, and the control word handed to each storage cell.
// No dependencies.
package dqs_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatW    = 2;
  localparam int unsigned PosW     = 4;
  localparam int unsigned OccW     = 5;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FIND       = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

// File: hdl/dqs_cell.sv
// One storage cell of the deque: holds one word, takes its lower or upper
// neighbor on a shift, loads the input word, and compares against the key.
// Depends on dqs_pkg.
module dqs_cell
  import dqs_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] lo_i,
  input  logic signed [DataW-1:0] hi_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    match_o
);

  logic signed [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = value_i;
    end else if (ctl_i.shift_up) begin
      data_d = lo_i;
    end else if (ctl_i.shift_down) begin
      data_d = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = valid_i && (data_q == value_i);

endmodule

// File: hdl/deque_with_linear_search.sv
// Deque of signed 32-bit words with a linear search, built as a row of
// shifting cells. Depends on dqs_pkg and dqs_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries command_i and value_i:
//   push front, push back, pop front, pop back or find. Every input word
//   yields exactly one result word on the output channel
//   (out_valid_o/out_ready_i): status_o, found_o, position_o, occupancy_o.
//   A word accepted at one edge is shown as a result from the next cycle on.
//   Throughput is one word per cycle while out_ready_i is high; all cells
//   shift and compare in parallel in the cycle a word is taken, and the
//   find position comes from a priority encoder over the match bits.
//   A push into a full store reports status full; a pop on an empty store
//   reports status empty; both leave the store unchanged.
//   Reset empties the store and drops any pending result; no clearing pass.
//   While the receiver stalls the result register holds and the input is
//   not taken; a new word is taken in the same cycle the result is taken.
module deque_with_linear_search
  import dqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CmdW-1:0]         command_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic                    found_o,
  output logic [PosW-1:0]         position_o,
  output logic [OccW-1:0]         occupancy_o
);

  logic            accept;
  logic            full, empty;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic            found_q, found_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            do_push_front, do_push_back, do_pop_front;

  cell_ctl_t                      ctl   [Capacity];
  logic signed [DataW-1:0]        data  [Capacity];
  logic signed [DataW-1:0]        lo    [Capacity];
  logic signed [DataW-1:0]        hi    [Capacity];
  logic [Capacity-1:0]            cvalid;
  logic [Capacity-1:0]            match;
  logic                           any_match;
  logic [IdxW-1:0]                first_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Capacity));
  assign empty      = (count_q == '0);

  assign do_push_front = accept && (cmd_e'(command_i) == CMD_PUSH_FRONT) && !full;
  assign do_push_back  = accept && (cmd_e'(command_i) == CMD_PUSH_BACK) && !full;
  assign do_pop_front  = accept && (cmd_e'(command_i) == CMD_POP_FRONT) && !empty;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign cvalid[i]         = (CntW'(i) < count_q);
    assign ctl[i].load       = (do_push_front && (i == 0)) ||
                               (do_push_back && (count_q == CntW'(i)));
    assign ctl[i].shift_up   = do_push_front;
    assign ctl[i].shift_down = do_pop_front;

    if (i == 0) begin : g_lo_edge
      assign lo[i] = data[i];
    end else begin : g_lo
      assign lo[i] = data[i-1];
    end
    if (i == Capacity - 1) begin : g_hi_edge
      assign hi[i] = data[i];
    end else begin : g_hi
      assign hi[i] = data[i+1];
    end

    dqs_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .valid_i (cvalid[i]),
      .value_i (value_i),
      .lo_i    (lo[i]),
      .hi_i    (hi[i]),
      .data_o  (data[i]),
      .match_o (match[i])
    );
  end

  // lowest matching position
  always_comb begin
    first_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end
  assign any_match = |match;

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    found_d  = 1'b0;
    pos_d    = '0;
    case (cmd_e'(command_i))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      CMD_FIND: begin
        found_d = any_match;
        pos_d   = any_match ? PosW'(first_idx) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      pos_q    <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign occupancy_o = OccW'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("occupancy above capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("occupancy changed without an accepted word");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (command_i == CMD_PUSH_FRONT || command_i == CMD_PUSH_BACK))
    |=> (status_q == ST_FULL) && full)
    else $error("push into full store not rejected");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (pos_q == '0))
    else $error("position set without a match");
`endif

endmodule
